[hw/rtl/c65ae_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c65ae_pkg
// Shared types and the opcode decode table for the 6502 arithmetic executor.
// ----------------------------------------------------------------------------
package c65ae_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 2;
  localparam int unsigned CycW  = 4;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [3:0] {
    KIND_NONE,
    KIND_ADC,
    KIND_SBC,
    KIND_CMP,
    KIND_CPX,
    KIND_CPY,
    KIND_DCP,
    KIND_DEC,
    KIND_DEX,
    KIND_DEY,
    KIND_INC,
    KIND_INX,
    KIND_INY,
    KIND_ISB,
    KIND_RRA
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [LenW-1:0]  len;
    logic [CycW-1:0]  cyc;
  } dec_t;

  typedef struct packed {
    dec_t             dec;
    logic [ByteW-1:0] operand;
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] xreg;
    logic [ByteW-1:0] yreg;
    logic             carry;
    logic             overflow;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] acc_out;
    logic [ByteW-1:0] xreg_out;
    logic [ByteW-1:0] yreg_out;
    logic [ByteW-1:0] mem_data;
    logic             mem_write;
    logic             neg_flag;
    logic             ovf_flag;
    logic             zero_flag;
    logic             carry_flag;
    logic [LenW-1:0]  instr_length;
    logic [CycW-1:0]  cycle_count;
    logic             recognized;
  } result_t;

  function automatic dec_t mk(kind_t k, int unsigned l, int unsigned c);
    dec_t d;
    d.kind = k;
    d.len  = LenW'(l);
    d.cyc  = CycW'(c);
    return d;
  endfunction

  function automatic dec_t decode(logic [ByteW-1:0] op);
    dec_t d;
    case (op)
      8'h69: d = mk(KIND_ADC, 2, 2);
      8'h65: d = mk(KIND_ADC, 2, 3);
      8'h75: d = mk(KIND_ADC, 2, 4);
      8'h6D: d = mk(KIND_ADC, 3, 4);
      8'h7D: d = mk(KIND_ADC, 3, 4);
      8'h79: d = mk(KIND_ADC, 3, 4);
      8'h61: d = mk(KIND_ADC, 2, 6);
      8'h71: d = mk(KIND_ADC, 2, 5);
      8'hE9: d = mk(KIND_SBC, 2, 2);
      8'hEB: d = mk(KIND_SBC, 2, 2);
      8'hE5: d = mk(KIND_SBC, 2, 3);
      8'hF5: d = mk(KIND_SBC, 2, 4);
      8'hED: d = mk(KIND_SBC, 3, 4);
      8'hFD: d = mk(KIND_SBC, 3, 4);
      8'hF9: d = mk(KIND_SBC, 3, 4);
      8'hE1: d = mk(KIND_SBC, 2, 6);
      8'hF1: d = mk(KIND_SBC, 2, 5);
      8'hC9: d = mk(KIND_CMP, 2, 2);
      8'hC5: d = mk(KIND_CMP, 2, 3);
      8'hD5: d = mk(KIND_CMP, 2, 4);
      8'hCD: d = mk(KIND_CMP, 3, 4);
      8'hDD: d = mk(KIND_CMP, 3, 4);
      8'hD9: d = mk(KIND_CMP, 3, 4);
      8'hC1: d = mk(KIND_CMP, 2, 6);
      8'hD1: d = mk(KIND_CMP, 2, 5);
      8'hE0: d = mk(KIND_CPX, 2, 2);
      8'hE4: d = mk(KIND_CPX, 2, 3);
      8'hEC: d = mk(KIND_CPX, 3, 4);
      8'hC0: d = mk(KIND_CPY, 2, 2);
      8'hC4: d = mk(KIND_CPY, 2, 3);
      8'hCC: d = mk(KIND_CPY, 3, 4);
      8'hC7: d = mk(KIND_DCP, 2, 5);
      8'hD7: d = mk(KIND_DCP, 2, 6);
      8'hCF: d = mk(KIND_DCP, 3, 6);
      8'hDF: d = mk(KIND_DCP, 3, 7);
      8'hDB: d = mk(KIND_DCP, 3, 7);
      8'hC3: d = mk(KIND_DCP, 2, 8);
      8'hD3: d = mk(KIND_DCP, 2, 8);
      8'hC6: d = mk(KIND_DEC, 2, 5);
      8'hD6: d = mk(KIND_DEC, 2, 6);
      8'hCE: d = mk(KIND_DEC, 3, 6);
      8'hDE: d = mk(KIND_DEC, 3, 7);
      8'hCA: d = mk(KIND_DEX, 1, 2);
      8'h88: d = mk(KIND_DEY, 1, 2);
      8'hE6: d = mk(KIND_INC, 2, 5);
      8'hF6: d = mk(KIND_INC, 2, 6);
      8'hEE: d = mk(KIND_INC, 3, 6);
      8'hFE: d = mk(KIND_INC, 3, 7);
      8'hE8: d = mk(KIND_INX, 1, 2);
      8'hC8: d = mk(KIND_INY, 1, 2);
      8'hE7: d = mk(KIND_ISB, 2, 5);
      8'hF7: d = mk(KIND_ISB, 2, 6);
      8'hEF: d = mk(KIND_ISB, 3, 6);
      8'hFF: d = mk(KIND_ISB, 3, 7);
      8'hFB: d = mk(KIND_ISB, 3, 7);
      8'hE3: d = mk(KIND_ISB, 2, 8);
      8'hF3: d = mk(KIND_ISB, 2, 8);
      8'h67: d = mk(KIND_RRA, 2, 5);
      8'h77: d = mk(KIND_RRA, 2, 6);
      8'h6F: d = mk(KIND_RRA, 3, 6);
      8'h7F: d = mk(KIND_RRA, 3, 7);
      8'h7B: d = mk(KIND_RRA, 3, 7);
      8'h63: d = mk(KIND_RRA, 2, 8);
      8'h73: d = mk(KIND_RRA, 2, 8);
      default: d = mk(KIND_NONE, 0, 0);
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/c65ae_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c65ae_front
// Accepts input words, decodes the opcode and holds the classified word.
// ----------------------------------------------------------------------------
module c65ae_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_opcode,
  input  logic [7:0]               in_operand,
  input  logic [7:0]               in_acc,
  input  logic [7:0]               in_xreg,
  input  logic [7:0]               in_yreg,
  input  logic                     in_carry,
  input  logic                     in_overflow,
  output logic                     out_valid,
  input  logic                     out_ready,
  output c65ae_pkg::item_t         out_item
);
  import c65ae_pkg::*;

  logic  vld;
  item_t item;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (out_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.dec      <= decode(in_opcode);
      item.operand  <= in_operand;
      item.acc      <= in_acc;
      item.xreg     <= in_xreg;
      item.yreg     <= in_yreg;
      item.carry    <= in_carry;
      item.overflow <= in_overflow;
    end
  end

endmodule

[hw/rtl/c65ae_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c65ae_queue
// Two-entry queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
module c65ae_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  c65ae_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output c65ae_pkg::item_t pop_item
);
  import c65ae_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[hw/rtl/c65ae_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c65ae_back
// Executes one classified word per cycle, while the output is not stalled, into a registered result.
// ----------------------------------------------------------------------------
module c65ae_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  c65ae_pkg::item_t   in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output c65ae_pkg::result_t out_result
);
  import c65ae_pkg::*;

  logic    vld;
  result_t res;
  result_t res_next;
  logic [7:0] lhs;
  logic [7:0] rhs;
  logic       cin;
  logic [8:0] sum;
  logic [7:0] m_inc;
  logic [7:0] m_dec;
  logic [7:0] nz_val;
  logic       is_add;

  assign in_ready   = !vld || out_ready;
  assign out_valid  = vld;
  assign out_result = res;

  assign m_inc = in_item.operand + 8'd1;
  assign m_dec = in_item.operand - 8'd1;

  always_comb begin
    lhs    = in_item.acc;
    rhs    = in_item.operand;
    cin    = in_item.carry;
    is_add = 1'b0;
    case (in_item.dec.kind)
      KIND_ADC: begin
        is_add = 1'b1;
      end
      KIND_SBC: begin
        rhs    = ~in_item.operand;
        is_add = 1'b1;
      end
      KIND_ISB: begin
        rhs    = ~m_inc;
        is_add = 1'b1;
      end
      KIND_RRA: begin
        rhs    = {in_item.carry, in_item.operand[7:1]};
        cin    = in_item.operand[0];
        is_add = 1'b1;
      end
      KIND_CMP: begin
        rhs = ~in_item.operand;
        cin = 1'b1;
      end
      KIND_CPX: begin
        lhs = in_item.xreg;
        rhs = ~in_item.operand;
        cin = 1'b1;
      end
      KIND_CPY: begin
        lhs = in_item.yreg;
        rhs = ~in_item.operand;
        cin = 1'b1;
      end
      KIND_DCP: begin
        rhs = ~m_dec;
        cin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sum = {1'b0, lhs} + {1'b0, rhs} + {8'd0, cin};

  always_comb begin
    res_next.acc_out      = in_item.acc;
    res_next.xreg_out     = in_item.xreg;
    res_next.yreg_out     = in_item.yreg;
    res_next.mem_data     = 8'd0;
    res_next.mem_write    = 1'b0;
    res_next.ovf_flag     = in_item.overflow;
    res_next.carry_flag   = in_item.carry;
    res_next.instr_length = in_item.dec.len;
    res_next.cycle_count  = in_item.dec.cyc;
    res_next.recognized   = (in_item.dec.kind != KIND_NONE);
    nz_val                = sum[7:0];
    if (is_add) begin
      res_next.acc_out    = sum[7:0];
      res_next.carry_flag = sum[8];
      res_next.ovf_flag   = ~(lhs[7] ^ rhs[7]) & (lhs[7] ^ sum[7]);
    end
    case (in_item.dec.kind)
      KIND_CMP, KIND_CPX, KIND_CPY: begin
        res_next.carry_flag = sum[8];
      end
      KIND_DCP: begin
        res_next.carry_flag = sum[8];
        res_next.mem_data   = m_dec;
        res_next.mem_write  = 1'b1;
      end
      KIND_DEC: begin
        res_next.mem_data  = m_dec;
        res_next.mem_write = 1'b1;
        nz_val             = m_dec;
      end
      KIND_INC: begin
        res_next.mem_data  = m_inc;
        res_next.mem_write = 1'b1;
        nz_val             = m_inc;
      end
      KIND_ISB: begin
        res_next.mem_data  = m_inc;
        res_next.mem_write = 1'b1;
      end
      KIND_RRA: begin
        res_next.mem_data  = rhs;
        res_next.mem_write = 1'b1;
      end
      KIND_DEX: begin
        res_next.xreg_out = in_item.xreg - 8'd1;
        nz_val            = res_next.xreg_out;
      end
      KIND_INX: begin
        res_next.xreg_out = in_item.xreg + 8'd1;
        nz_val            = res_next.xreg_out;
      end
      KIND_DEY: begin
        res_next.yreg_out = in_item.yreg - 8'd1;
        nz_val            = res_next.yreg_out;
      end
      KIND_INY: begin
        res_next.yreg_out = in_item.yreg + 8'd1;
        nz_val            = res_next.yreg_out;
      end
      default: begin
      end
    endcase
    res_next.neg_flag  = res_next.recognized && nz_val[7];
    res_next.zero_flag = res_next.recognized && (nz_val == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (out_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res <= res_next;
    end
  end

endmodule

[hw/rtl/cpu6502_arith_execute.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu6502_arith_execute
// Binary-mode 6502 arithmetic group: decode front, queue, execute back.
// ----------------------------------------------------------------------------
// A word accepted passes the front register and the queue into the result register.
// Throughput: one word per cycle while the output is not stalled.
// The two-entry queue lets the front keep accepting while the output stalls, until it fills.
// Reset (rst, synchronous, active high) empties the front, queue and output.
module cpu6502_arith_execute (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] operand, [15:8] acc_in, [23:16] xreg_in, [31:24] yreg_in,
  // [32] carry_in, [33] overflow_in, [39:34] zero
  input  logic [c65ae_pkg::InDataW-1:0]    s_axis_tdata,
  // [7:0] req_type
  input  logic [7:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] acc_out, [15:8] xreg_out, [23:16] yreg_out, [31:24] mem_data,
  // [32] mem_write, [33] neg_flag, [34] ovf_flag, [35] zero_flag,
  // [36] carry_flag, [38:37] instr_length, [42:39] cycle_count, [47:43] zero
  output logic [c65ae_pkg::OutDataW-1:0]   m_axis_tdata,
  // [0] recognized
  output logic                             m_axis_tuser
);
  import c65ae_pkg::*;

  logic    f_valid;
  logic    f_ready;
  item_t   f_item;
  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  result_t res;

  c65ae_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_opcode   (s_axis_tuser),
    .in_operand  (s_axis_tdata[7:0]),
    .in_acc      (s_axis_tdata[15:8]),
    .in_xreg     (s_axis_tdata[23:16]),
    .in_yreg     (s_axis_tdata[31:24]),
    .in_carry    (s_axis_tdata[32]),
    .in_overflow (s_axis_tdata[33]),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_item    (f_item)
  );

  c65ae_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  c65ae_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (res)
  );

  assign m_axis_tdata = {5'd0, res.cycle_count, res.instr_length, res.carry_flag,
                         res.zero_flag, res.ovf_flag, res.neg_flag, res.mem_write,
                         res.mem_data, res.yreg_out, res.xreg_out, res.acc_out};
  assign m_axis_tuser = res.recognized;

endmodule

[hw/rtl/c65ae_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c65ae_checker
// Port-level checks for the arithmetic executor, bound to the top level.
// ----------------------------------------------------------------------------
module c65ae_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Output word changed while stalled.");

  a_unknown_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[42:37] == 6'd0 && !m_axis_tdata[32] && !m_axis_tdata[33]
      && !m_axis_tdata[35] && m_axis_tdata[31:24] == 8'd0)
    else $error("Unrecognized opcode produced results.");

  a_known_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[38:37] != 2'd0 && m_axis_tdata[42:39] >= 4'd2)
    else $error("Recognized opcode with empty length or cycle count.");

  a_rmw_cycles: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[42:39] >= 4'd5)
    else $error("Write-back charged fewer than five cycles.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("Output valid right after reset.");

endmodule

bind cpu6502_arith_execute c65ae_checker u_c65ae_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[dv/tb_cpu6502_arith_execute.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu6502_arith_execute
// Self-checking testbench for the binary-mode 6502 arithmetic executor.
// ----------------------------------------------------------------------------
// Instruction words are pushed into the input stream while a local model of
// the arithmetic group computes the result word that each one must produce.
// A monitor compares every output word field by field, in order, against the
// oldest prediction. Directed corner cases come first, then a sweep of all
// 256 opcodes, then random instruction words under four handshake patterns.
// ----------------------------------------------------------------------------
module tb_cpu6502_arith_execute;

  import c65ae_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RandomPerPhase = 170;

  typedef struct {
    logic [7:0] opcode;
    logic [7:0] operand;
    logic [7:0] acc;
    logic [7:0] xreg;
    logic [7:0] yreg;
    logic       carry;
    logic       ovf;
  } insn_t;

  typedef struct {
    logic [7:0] acc;
    logic [7:0] xreg;
    logic [7:0] yreg;
    logic [7:0] mem_data;
    logic       mem_write;
    logic       neg;
    logic       ovf;
    logic       zero;
    logic       carry;
    logic [1:0] length;
    logic [3:0] cycles;
    logic [4:0] pad;
    logic       recognized;
  } exec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [7:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  exec_result_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  words_sent = 0;
  int unsigned  known_sent = 0;
  int unsigned  results_checked = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  sink_stall_pct = 0;

  cpu6502_arith_execute i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk = ~clk;

  function automatic void arith_decode(input logic [7:0] op, output kind_t kind,
                                       output logic [1:0] len, output logic [3:0] cyc);
    kind = KIND_NONE;
    len  = 2'd0;
    cyc  = 4'd0;
    case (op)
      8'h69: begin kind = KIND_ADC; len = 2'd2; cyc = 4'd2; end
      8'h65: begin kind = KIND_ADC; len = 2'd2; cyc = 4'd3; end
      8'h75: begin kind = KIND_ADC; len = 2'd2; cyc = 4'd4; end
      8'h6D: begin kind = KIND_ADC; len = 2'd3; cyc = 4'd4; end
      8'h7D: begin kind = KIND_ADC; len = 2'd3; cyc = 4'd4; end
      8'h79: begin kind = KIND_ADC; len = 2'd3; cyc = 4'd4; end
      8'h61: begin kind = KIND_ADC; len = 2'd2; cyc = 4'd6; end
      8'h71: begin kind = KIND_ADC; len = 2'd2; cyc = 4'd5; end
      8'hE9: begin kind = KIND_SBC; len = 2'd2; cyc = 4'd2; end
      8'hEB: begin kind = KIND_SBC; len = 2'd2; cyc = 4'd2; end
      8'hE5: begin kind = KIND_SBC; len = 2'd2; cyc = 4'd3; end
      8'hF5: begin kind = KIND_SBC; len = 2'd2; cyc = 4'd4; end
      8'hED: begin kind = KIND_SBC; len = 2'd3; cyc = 4'd4; end
      8'hFD: begin kind = KIND_SBC; len = 2'd3; cyc = 4'd4; end
      8'hF9: begin kind = KIND_SBC; len = 2'd3; cyc = 4'd4; end
      8'hE1: begin kind = KIND_SBC; len = 2'd2; cyc = 4'd6; end
      8'hF1: begin kind = KIND_SBC; len = 2'd2; cyc = 4'd5; end
      8'hC9: begin kind = KIND_CMP; len = 2'd2; cyc = 4'd2; end
      8'hC5: begin kind = KIND_CMP; len = 2'd2; cyc = 4'd3; end
      8'hD5: begin kind = KIND_CMP; len = 2'd2; cyc = 4'd4; end
      8'hCD: begin kind = KIND_CMP; len = 2'd3; cyc = 4'd4; end
      8'hDD: begin kind = KIND_CMP; len = 2'd3; cyc = 4'd4; end
      8'hD9: begin kind = KIND_CMP; len = 2'd3; cyc = 4'd4; end
      8'hC1: begin kind = KIND_CMP; len = 2'd2; cyc = 4'd6; end
      8'hD1: begin kind = KIND_CMP; len = 2'd2; cyc = 4'd5; end
      8'hE0: begin kind = KIND_CPX; len = 2'd2; cyc = 4'd2; end
      8'hE4: begin kind = KIND_CPX; len = 2'd2; cyc = 4'd3; end
      8'hEC: begin kind = KIND_CPX; len = 2'd3; cyc = 4'd4; end
      8'hC0: begin kind = KIND_CPY; len = 2'd2; cyc = 4'd2; end
      8'hC4: begin kind = KIND_CPY; len = 2'd2; cyc = 4'd3; end
      8'hCC: begin kind = KIND_CPY; len = 2'd3; cyc = 4'd4; end
      8'hC7: begin kind = KIND_DCP; len = 2'd2; cyc = 4'd5; end
      8'hD7: begin kind = KIND_DCP; len = 2'd2; cyc = 4'd6; end
      8'hCF: begin kind = KIND_DCP; len = 2'd3; cyc = 4'd6; end
      8'hDF: begin kind = KIND_DCP; len = 2'd3; cyc = 4'd7; end
      8'hDB: begin kind = KIND_DCP; len = 2'd3; cyc = 4'd7; end
      8'hC3: begin kind = KIND_DCP; len = 2'd2; cyc = 4'd8; end
      8'hD3: begin kind = KIND_DCP; len = 2'd2; cyc = 4'd8; end
      8'hC6: begin kind = KIND_DEC; len = 2'd2; cyc = 4'd5; end
      8'hD6: begin kind = KIND_DEC; len = 2'd2; cyc = 4'd6; end
      8'hCE: begin kind = KIND_DEC; len = 2'd3; cyc = 4'd6; end
      8'hDE: begin kind = KIND_DEC; len = 2'd3; cyc = 4'd7; end
      8'hCA: begin kind = KIND_DEX; len = 2'd1; cyc = 4'd2; end
      8'h88: begin kind = KIND_DEY; len = 2'd1; cyc = 4'd2; end
      8'hE6: begin kind = KIND_INC; len = 2'd2; cyc = 4'd5; end
      8'hF6: begin kind = KIND_INC; len = 2'd2; cyc = 4'd6; end
      8'hEE: begin kind = KIND_INC; len = 2'd3; cyc = 4'd6; end
      8'hFE: begin kind = KIND_INC; len = 2'd3; cyc = 4'd7; end
      8'hE8: begin kind = KIND_INX; len = 2'd1; cyc = 4'd2; end
      8'hC8: begin kind = KIND_INY; len = 2'd1; cyc = 4'd2; end
      8'hE7: begin kind = KIND_ISB; len = 2'd2; cyc = 4'd5; end
      8'hF7: begin kind = KIND_ISB; len = 2'd2; cyc = 4'd6; end
      8'hEF: begin kind = KIND_ISB; len = 2'd3; cyc = 4'd6; end
      8'hFF: begin kind = KIND_ISB; len = 2'd3; cyc = 4'd7; end
      8'hFB: begin kind = KIND_ISB; len = 2'd3; cyc = 4'd7; end
      8'hE3: begin kind = KIND_ISB; len = 2'd2; cyc = 4'd8; end
      8'hF3: begin kind = KIND_ISB; len = 2'd2; cyc = 4'd8; end
      8'h67: begin kind = KIND_RRA; len = 2'd2; cyc = 4'd5; end
      8'h77: begin kind = KIND_RRA; len = 2'd2; cyc = 4'd6; end
      8'h6F: begin kind = KIND_RRA; len = 2'd3; cyc = 4'd6; end
      8'h7F: begin kind = KIND_RRA; len = 2'd3; cyc = 4'd7; end
      8'h7B: begin kind = KIND_RRA; len = 2'd3; cyc = 4'd7; end
      8'h63: begin kind = KIND_RRA; len = 2'd2; cyc = 4'd8; end
      8'h73: begin kind = KIND_RRA; len = 2'd2; cyc = 4'd8; end
      default: ;
    endcase
  endfunction

  function automatic void add_with_carry(inout logic [7:0] acc, input logic [7:0] m,
                                         inout logic carry, inout logic ovf);
    logic [8:0] sum;
    sum   = {1'b0, acc} + {1'b0, m} + {8'd0, carry};
    carry = sum[8];
    ovf   = ~(acc[7] ^ m[7]) & (acc[7] ^ sum[7]);
    acc   = sum[7:0];
  endfunction

  function automatic void compare_regs(input logic [7:0] r, input logic [7:0] m,
                                       output logic carry, output logic neg,
                                       output logic zero);
    logic [7:0] diff;
    diff  = r - m;
    carry = (r >= m);
    neg   = diff[7];
    zero  = (diff == 8'd0);
  endfunction

  function automatic exec_result_t execute_insn(insn_t w);
    exec_result_t res;
    kind_t        kind;
    logic [7:0]   a, x, y, md, nz_src;
    logic         c, v, n, z, mw, nz_valid;
    a = w.acc; x = w.xreg; y = w.yreg; c = w.carry; v = w.ovf;
    n = 1'b0; z = 1'b0; md = 8'd0; mw = 1'b0;
    arith_decode(w.opcode, kind, res.length, res.cycles);
    case (kind)
      KIND_ADC: add_with_carry(a, w.operand, c, v);
      KIND_SBC: add_with_carry(a, ~w.operand, c, v);
      KIND_CMP: compare_regs(a, w.operand, c, n, z);
      KIND_CPX: compare_regs(x, w.operand, c, n, z);
      KIND_CPY: compare_regs(y, w.operand, c, n, z);
      KIND_DCP: begin
        md = w.operand - 8'd1; mw = 1'b1;
        compare_regs(a, md, c, n, z);
      end
      KIND_DEC: begin md = w.operand - 8'd1; mw = 1'b1; end
      KIND_INC: begin md = w.operand + 8'd1; mw = 1'b1; end
      KIND_ISB: begin
        md = w.operand + 8'd1; mw = 1'b1;
        add_with_carry(a, ~md, c, v);
      end
      KIND_RRA: begin
        md = {c, w.operand[7:1]}; mw = 1'b1;
        c = w.operand[0];
        add_with_carry(a, md, c, v);
      end
      KIND_DEX: x = x - 8'd1;
      KIND_DEY: y = y - 8'd1;
      KIND_INX: x = x + 8'd1;
      KIND_INY: y = y + 8'd1;
      default: ;
    endcase
    nz_valid = 1'b1;
    case (kind)
      KIND_ADC, KIND_SBC, KIND_ISB, KIND_RRA: nz_src = a;
      KIND_DEC, KIND_INC:                     nz_src = md;
      KIND_DEX, KIND_INX:                     nz_src = x;
      KIND_DEY, KIND_INY:                     nz_src = y;
      default: begin nz_src = 8'd0; nz_valid = 1'b0; end
    endcase
    if (nz_valid) begin
      n = nz_src[7];
      z = (nz_src == 8'd0);
    end
    res.acc = a; res.xreg = x; res.yreg = y;
    res.mem_data = md; res.mem_write = mw;
    res.neg = n; res.ovf = v; res.zero = z; res.carry = c;
    res.pad = 5'd0;
    res.recognized = (kind != KIND_NONE);
    return res;
  endfunction

  function automatic logic [7:0] edgy_byte();
    logic [7:0] corners[6];
    corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(99) < 20) begin
      return corners[$urandom_range(5)];
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic insn_t random_insn();
    insn_t      w;
    kind_t      kind;
    logic [1:0] len;
    logic [3:0] cyc;
    w.opcode = 8'($urandom_range(255));
    if ($urandom_range(99) < 88) begin
      arith_decode(w.opcode, kind, len, cyc);
      while (kind == KIND_NONE) begin
        w.opcode = 8'($urandom_range(255));
        arith_decode(w.opcode, kind, len, cyc);
      end
    end
    w.operand = edgy_byte();
    w.acc     = edgy_byte();
    w.xreg    = edgy_byte();
    w.yreg    = edgy_byte();
    w.carry   = 1'($urandom_range(1));
    w.ovf     = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic send_insn(insn_t w);
    exec_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.opcode;
    s_axis_tdata  <= {6'd0, w.ovf, w.carry, w.yreg, w.xreg, w.acc, w.operand};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    res = execute_insn(w);
    pending_results.push_back(res);
    words_sent++;
    if (res.recognized) known_sent++;
  endtask

  task automatic send_fields(logic [7:0] op, logic [7:0] m, logic [7:0] a,
                             logic [7:0] x, logic [7:0] y, logic c, logic v);
    insn_t w;
    w = '{op, m, a, x, y, c, v};
    send_insn(w);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : result_monitor
    exec_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual 0x%0h/%0b",
                 $time, m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("acc_out", want.acc, m_axis_tdata[7:0]);
        compare_field("xreg_out", want.xreg, m_axis_tdata[15:8]);
        compare_field("yreg_out", want.yreg, m_axis_tdata[23:16]);
        compare_field("mem_data", want.mem_data, m_axis_tdata[31:24]);
        compare_field("mem_write", 8'(want.mem_write), 8'(m_axis_tdata[32]));
        compare_field("neg_flag", 8'(want.neg), 8'(m_axis_tdata[33]));
        compare_field("ovf_flag", 8'(want.ovf), 8'(m_axis_tdata[34]));
        compare_field("zero_flag", 8'(want.zero), 8'(m_axis_tdata[35]));
        compare_field("carry_flag", 8'(want.carry), 8'(m_axis_tdata[36]));
        compare_field("instr_length", 8'(want.length), 8'(m_axis_tdata[38:37]));
        compare_field("cycle_count", 8'(want.cycles), 8'(m_axis_tdata[42:39]));
        compare_field("tdata padding", 8'(want.pad), 8'(m_axis_tdata[47:43]));
        compare_field("recognized", 8'(want.recognized), 8'(m_axis_tuser));
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic test_corner_cases();
    src_idle_pct = 0; sink_stall_pct = 0;
    send_fields(8'h69, 8'h01, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0);  // carry out, result 0x01
    send_fields(8'h69, 8'h01, 8'h7F, 8'h00, 8'h00, 1'b0, 1'b0);  // signed overflow
    send_fields(8'h71, 8'hFF, 8'h80, 8'hFF, 8'hFF, 1'b0, 1'b1);  // negative overflow
    send_fields(8'hE9, 8'h01, 8'h80, 8'h00, 8'h00, 1'b1, 1'b0);  // SBC overflow
    send_fields(8'hEB, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);  // SBC alias, borrow
    send_fields(8'hC9, 8'h40, 8'h40, 8'h00, 8'h00, 1'b0, 1'b1);  // CMP equal
    send_fields(8'hC5, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);  // CMP less
    send_fields(8'hE0, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1);  // CPX greater
    send_fields(8'hCC, 8'h81, 8'h00, 8'h00, 8'h01, 1'b1, 1'b0);  // CPY
    send_fields(8'hE6, 8'hFF, 8'h12, 8'h34, 8'h56, 1'b1, 1'b1);  // INC wraps to zero
    send_fields(8'hDE, 8'h00, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0);  // DEC wraps to FF
    send_fields(8'hE8, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1);  // INX wrap
    send_fields(8'hC8, 8'hFF, 8'h00, 8'h00, 8'h7F, 1'b0, 1'b0);  // INY to negative
    send_fields(8'hCA, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);  // DEX wrap
    send_fields(8'h88, 8'h00, 8'hFF, 8'hFF, 8'h01, 1'b1, 1'b0);  // DEY to zero
    send_fields(8'hC7, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1);  // DCP wraps operand
    send_fields(8'hD3, 8'h41, 8'h40, 8'h00, 8'h00, 1'b1, 1'b0);  // DCP equal
    send_fields(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);  // ISB wraps operand
    send_fields(8'hE3, 8'h7F, 8'h80, 8'h00, 8'h00, 1'b1, 1'b1);  // ISB to zero, no overflow
    send_fields(8'h67, 8'h01, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0);  // RRA carry in and out
    send_fields(8'h73, 8'hFE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);  // RRA no carry
    send_fields(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);  // unknown, all ones
    send_fields(8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);  // unknown, all zeros
    drain_results();
  endtask

  task automatic test_opcode_sweep();
    insn_t w;
    src_idle_pct = 13; sink_stall_pct = 13;
    for (int op = 0; op < 256; op++) begin
      w = random_insn();
      w.opcode = 8'(op);
      send_insn(w);
    end
    drain_results();
  endtask

  task automatic test_random_phase(int unsigned src_pct, int unsigned sink_pct, bit pause);
    src_idle_pct = src_pct; sink_stall_pct = sink_pct;
    for (int i = 0; i < RandomPerPhase; i++) begin
      send_insn(random_insn());
      if (pause && i == RandomPerPhase / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_opcode_sweep();
    test_random_phase(0, 0, 1'b1);
    test_random_phase(62, 0, 1'b0);
    test_random_phase(0, 62, 1'b1);
    test_random_phase(13, 13, 1'b0);
    s_axis_tvalid <= 1'b0;
    sink_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d instruction words (%0d arithmetic, %0d unknown opcodes) under four",
             words_sent, known_sent, words_sent - known_sent);
    $display("handshake patterns; checked %0d result words, %0d errors.",
             results_checked, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
